// ===== rtl/core/polyline_character_decoder_top_macros.svh =====
// Assertion macros for the polyline character decoder.
// Used by modules that have clk_i and rst_ni in scope; no other dependencies.
`ifndef POLYLINE_CHARACTER_DECODER_TOP_MACROS_SVH
`define POLYLINE_CHARACTER_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcd_pkg.sv =====
// Shared types and constants for the polyline character decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package pcd_pkg;

  localparam int unsigned MAX_CHUNKS_DEF  = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CHAR_OFFSET = 8'd63;
  localparam logic [7:0] CHAR_TOP    = 8'd126;
  localparam int unsigned CHUNK_W    = 5;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned COUNT_W    = 3;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CHAR  = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_MID_POINT = 2'd3
  } pcd_status_e;

  // One classified character as it travels from front to back.
  typedef struct packed {
    logic               bad;
    logic               more;
    logic [CHUNK_W-1:0] payload;
    logic               last;
  } pcd_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/pcd_front.sv =====
// Front end: accept characters, classify them and push them into the queue.
// Depends on pcd_pkg.
`default_nettype none

module pcd_front (
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              string_end_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output pcd_pkg::pcd_item_t     q_item_o
);
  import pcd_pkg::*;

  logic [7:0] chunk;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Offset the byte; only meaningful when it lies in the legal range.
  assign chunk = char_code_i - CHAR_OFFSET;

  always_comb begin
    q_item_o.bad     = (char_code_i < CHAR_OFFSET) || (char_code_i > CHAR_TOP);
    q_item_o.more    = chunk[CHUNK_W];
    q_item_o.payload = chunk[CHUNK_W-1:0];
    q_item_o.last    = string_end_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcd_queue.sv =====
// Short FIFO between the front and back ends of the decoder.
// Depends on pcd_pkg for the item type.
`default_nettype none

module pcd_queue #(
  parameter int unsigned DEPTH = pcd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire pcd_pkg::pcd_item_t item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output pcd_pkg::pcd_item_t      item_o
);
  import pcd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  pcd_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pcd_back.sv =====
// Back end: gather chunks, unzigzag, accumulate and register the results.
// Depends on pcd_pkg and the assertion macro header.
`default_nettype none
`include "polyline_character_decoder_top_macros.svh"

module pcd_back #(
  parameter int unsigned MAX_CHUNKS = pcd_pkg::MAX_CHUNKS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire pcd_pkg::pcd_item_t q_item_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      latitude_e5_o,
  output logic signed [31:0]      longitude_e5_o,
  output logic [1:0]              status_o,
  output logic                    last_of_string_o
);
  import pcd_pkg::*;

  logic [COORD_W-1:0] partial_q, partial_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               on_lon_q, on_lon_d;
  logic [COORD_W-1:0] lat_q, lat_d;
  logic [COORD_W-1:0] lon_q, lon_d;
  logic               err_q, err_d;

  logic               out_valid_q, out_valid_d;
  logic [COORD_W-1:0] out_lat_q, out_lat_d;
  logic [COORD_W-1:0] out_lon_q, out_lon_d;
  pcd_status_e        out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  logic               emit;
  logic [5:0]         shamt;
  logic [COORD_W-1:0] gathered;
  logic [COORD_W-1:0] delta;
  logic [COORD_W-1:0] sum;
  logic               too_long;

  assign q_pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  assign shamt    = 6'(count_q) * 6'd5;
  assign gathered = partial_q | ({{(COORD_W-CHUNK_W){1'b0}}, q_item_i.payload} << shamt);
  assign delta    = gathered[0] ? ~(gathered >> 1) : (gathered >> 1);
  assign sum      = (on_lon_q ? lon_q : lat_q) + delta;
  assign too_long = ({1'b0, count_q} + 4'd1) >= 4'(MAX_CHUNKS);

  always_comb begin
    partial_d    = partial_q;
    count_d      = count_q;
    on_lon_d     = on_lon_q;
    lat_d        = lat_q;
    lon_d        = lon_q;
    err_d        = err_q;
    emit         = 1'b0;
    out_lat_d    = out_lat_q;
    out_lon_d    = out_lon_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    if (q_pop_o) begin
      if (err_q) begin
        // drop everything until the string closes
      end else if (q_item_i.bad || (q_item_i.more && too_long)) begin
        emit         = 1'b1;
        out_status_d = q_item_i.bad ? ST_BAD_CHAR : ST_TOO_LONG;
        out_lat_d    = '0;
        out_lon_d    = '0;
        err_d        = 1'b1;
      end else if (q_item_i.more) begin
        partial_d = gathered;
        count_d   = count_q + COUNT_W'(1);
        if (q_item_i.last) begin
          emit         = 1'b1;
          out_status_d = ST_MID_POINT;
          out_lat_d    = '0;
          out_lon_d    = '0;
        end
      end else begin
        partial_d = '0;
        count_d   = '0;
        on_lon_d  = !on_lon_q;
        if (on_lon_q) begin
          lon_d        = sum;
          emit         = 1'b1;
          out_status_d = ST_OK;
          out_lat_d    = lat_q;
          out_lon_d    = sum;
        end else begin
          lat_d = sum;
          if (q_item_i.last) begin
            emit         = 1'b1;
            out_status_d = ST_MID_POINT;
            out_lat_d    = '0;
            out_lon_d    = '0;
          end
        end
      end

      if (emit) begin
        out_valid_d = 1'b1;
        out_last_d  = q_item_i.last;
      end

      // End of string returns all decode state to its reset value.
      if (q_item_i.last) begin
        partial_d = '0;
        count_d   = '0;
        on_lon_d  = 1'b0;
        lat_d     = '0;
        lon_d     = '0;
        err_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      count_q     <= '0;
      on_lon_q    <= 1'b0;
      lat_q       <= '0;
      lon_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      partial_q   <= partial_d;
      count_q     <= count_d;
      on_lon_q    <= on_lon_d;
      lat_q       <= lat_d;
      lon_q       <= lon_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_lat_q    <= out_lat_d;
    out_lon_q    <= out_lon_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign latitude_e5_o    = signed'(out_lat_q);
  assign longitude_e5_o   = signed'(out_lon_q);
  assign status_o         = out_status_q;
  assign last_of_string_o = out_last_q;

  `PCD_ASSERT_NOW(a_err_zero_coords, out_valid_q && (out_status_q != ST_OK), (out_lat_q == '0) && (out_lon_q == '0), "error result carries nonzero coordinates")
  `PCD_ASSERT_NOW(a_mid_point_last, out_valid_q && (out_status_q == ST_MID_POINT), out_last_q, "mid-point result does not close the string")
  `PCD_ASSERT_NEXT(a_err_sticky, q_pop_o && emit && !q_item_i.last && ((out_status_d == ST_BAD_CHAR) || (out_status_d == ST_TOO_LONG)), err_q, "error flag not set after error result")
  `PCD_ASSERT_NOW(a_count_bound, 1'b1, {1'b0, count_q} < 4'(MAX_CHUNKS), "chunk count past limit")

endmodule

`default_nettype wire

// ===== rtl/core/polyline_character_decoder_top.sv =====
// Top level of the encoded polyline decoder: front end, queue, back end.
// Depends on pcd_pkg, pcd_front, pcd_queue and pcd_back.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o) takes one request per cycle while in_ready_o is high: one
//   character byte plus string_end_i on the last byte of a string.
// - Output channel (out_valid_o / out_ready_i) delivers at most one result per
//   character: a point after each longitude, an error (bad character or value
//   past MAX_CHUNKS chunks), or a mid-point status when a string ends early.
//   After an error the rest of that string is dropped silently.
// - Path: an accepted character is written into the queue; the back end pops it
//   and registers its result in the output register.
// - Throughput: one character per cycle while out_ready_i is high; the back end
//   does one shift-or and one 32-bit add per character.
// - Stall: when out_ready_i is low the result holds in the output register,
//   the back end stops popping and the QUEUE_DEPTH-entry queue fills; then
//   in_ready_o drops. Characters that give no result still drain only while
//   the output register is free or being taken.
// - Reset (rst_ni low, async) empties the queue, drops any pending result and
//   clears sums, partial value, chunk count, axis select and error flag.
`default_nettype none

module polyline_character_decoder_top #(
  parameter int unsigned MAX_CHUNKS  = pcd_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned QUEUE_DEPTH = pcd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [7:0]   char_code_i,
  input  wire logic         string_end_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic signed [31:0] latitude_e5_o,
  output logic signed [31:0] longitude_e5_o,
  output logic [1:0]        status_o,
  output logic              last_of_string_o
);
  import pcd_pkg::*;

  // Front to queue.
  logic      q_full;
  logic      q_push;
  pcd_item_t q_wr_item;

  // Queue to back.
  logic      q_valid;
  logic      q_pop;
  pcd_item_t q_rd_item;

  pcd_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_code_i  (char_code_i),
    .string_end_i (string_end_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_wr_item)
  );

  pcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_wr_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_rd_item)
  );

  // Back end owns all decode state and the output register.
  pcd_back #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_rd_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .latitude_e5_o    (latitude_e5_o),
    .longitude_e5_o   (longitude_e5_o),
    .status_o         (status_o),
    .last_of_string_o (last_of_string_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_polyline_character_decoder_top.sv =====
// Self-checking testbench for polyline_character_decoder_top.
// Depends on pcd_pkg and the RTL under rtl/core; it reads no files and needs no arguments.
`timescale 1ns / 1ps

module tb_polyline_character_decoder_top;
  import pcd_pkg::*;

  localparam int unsigned MAX_CHUNKS   = MAX_CHUNKS_DEF;
  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 7;
  localparam int          N_ITEMS      = 1350;
  // Long receiver hold-off: the queue fills and in_ready_o has to drop.
  localparam int          HOLD_CYCLES  = 400;
  // Slack after the last due result, to catch stray results.
  localparam int          DRAIN_CYCLES = 8;
  localparam int          TIMEOUT_NS   = 5_000_000;
  localparam int          MAX_REPORTS  = 10;

  // One decoded result as it leaves the block.
  typedef struct packed {
    logic [31:0] lat;
    logic [31:0] lon;
    pcd_status_e status;
    logic        last;
  } fix_t;

  // Tracks decoder state per accepted request and holds the results that are due.
  class polyline_tracker;
    logic [31:0] partial;
    int unsigned chunk_count;
    bit          on_lon;
    logic [31:0] lat_sum;
    logic [31:0] lon_sum;
    bit          error_seen;
    fix_t        fixes_due[$];
    int          mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      partial     = '0;
      chunk_count = 0;
      on_lon      = 1'b0;
      lat_sum     = '0;
      lon_sum     = '0;
      error_seen  = 1'b0;
    endfunction

    // Undo the zigzag sign folding: odd values are negative.
    function logic [31:0] unzig(logic [31:0] v);
      return v[0] ? ~(v >> 1) : (v >> 1);
    endfunction

    // Advance the state by one accepted character; return 0 if it was dropped.
    function bit note_char(logic [7:0] code, logic closes);
      fix_t        fix;
      logic [5:0]  chunk;
      logic [31:0] delta;
      int unsigned shift;
      bit          point;
      pcd_status_e st;
      if (error_seen) begin
        if (closes) clear();
        return 1'b0;
      end
      st    = ST_OK;
      point = 1'b0;
      if (code < CHAR_OFFSET || code > CHAR_TOP) begin
        st = ST_BAD_CHAR;
      end else begin
        chunk = 6'(code - CHAR_OFFSET);
        shift = 5 * chunk_count;
        // Payload past bit 31 falls off the top.
        if (shift < 32) partial = partial | (32'(chunk[4:0]) << shift);
        if (chunk[5]) begin
          if (chunk_count + 1 >= MAX_CHUNKS) st = ST_TOO_LONG;
          else chunk_count = chunk_count + 1;
        end else begin
          delta       = unzig(partial);
          partial     = '0;
          chunk_count = 0;
          if (on_lon) begin
            lon_sum = lon_sum + delta;
            on_lon  = 1'b0;
            point   = 1'b1;
          end else begin
            lat_sum = lat_sum + delta;
            on_lon  = 1'b1;
          end
        end
      end
      fix.last = closes;
      if (st != ST_OK) begin
        fix.lat    = '0;
        fix.lon    = '0;
        fix.status = st;
        fixes_due  = {fixes_due, fix};
        if (closes) clear();
        else error_seen = 1'b1;
      end else if (point) begin
        fix.lat    = lat_sum;
        fix.lon    = lon_sum;
        fix.status = ST_OK;
        fixes_due  = {fixes_due, fix};
        if (closes) clear();
      end else if (closes) begin
        fix.lat    = '0;
        fix.lon    = '0;
        fix.status = ST_MID_POINT;
        fixes_due  = {fixes_due, fix};
        clear();
      end
      return 1'b1;
    endfunction

    function void flag(string why, fix_t want, fix_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s: want lat=%0d lon=%0d status=%s last=%0b, %s",
                 $realtime, why, $signed(want.lat), $signed(want.lon),
                 want.status.name(), want.last,
                 $sformatf("got lat=%0d lon=%0d status=%s last=%0b",
                           $signed(got.lat), $signed(got.lon),
                           got.status.name(), got.last));
    endfunction

    // Compare one accepted result against the oldest one due.
    function void check_fix(fix_t got);
      fix_t want;
      if (fixes_due.size() == 0) begin
        want = '0;
        flag("result with nothing due", want, got);
        return;
      end
      want = fixes_due.pop_front();
      if (got.lat !== want.lat || got.lon !== want.lon ||
          got.status !== want.status || got.last !== want.last)
        flag("result mismatch", want, got);
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i    = '0;
  logic        string_end_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic signed [31:0] latitude_e5_o;
  logic signed [31:0] longitude_e5_o;
  logic [1:0]  status_o;
  logic        last_of_string_o;

  polyline_tracker tracker = new();
  logic [7:0]  line_q[$];     // characters of the string being built
  int          sent_chars = 0; // requests accepted so far
  int          send_calm  = 0;
  int          take_calm  = 0;
  bit          hold_request = 1'b0;

  polyline_character_decoder_top #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .string_end_i     (string_end_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .latitude_e5_o    (latitude_e5_o),
    .longitude_e5_o   (longitude_e5_o),
    .status_o         (status_o),
    .last_of_string_o (last_of_string_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Draw the idle cycles before the next request. Now and then start a calm
  // stretch with no idling at all so back-to-back traffic gets exercised.
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(16, 64);
      return 0;
    end
    return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 17) : $urandom_range(0, 3);
  endfunction

  // Append one value in polyline form: zigzag, then 5-bit chunks, low first.
  function automatic void push_value(logic [31:0] v);
    logic [31:0] zz;
    zz = {v[30:0], 1'b0} ^ {32{v[31]}};
    while (zz >= 32) begin
      line_q = {line_q, 8'(zz[4:0]) + 8'h20 + CHAR_OFFSET};
      zz = zz >> 5;
    end
    line_q = {line_q, 8'(zz[4:0]) + CHAR_OFFSET};
  endfunction

  // Pick a coordinate step: small and medium moves, some full-range and edge values.
  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 64)) - 32'd32;
      1: return 32'($urandom_range(0, 200000)) - 32'd100000;
      2: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic void push_run(logic [7:0] code, int n);
    repeat (n) line_q = {line_q, code};
  endfunction

  // Offer one request and hold it until the handshake. Sample ready at the
  // falling edge so the decision never races the rising edge.
  task automatic send_char(input logic [7:0] code, input logic closes);
    int gap;
    bit taken;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    char_code_i  <= code;
    string_end_i <= closes;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    void'(tracker.note_char(code, closes));
    sent_chars++;
  endtask

  // Send the built string, marking its last character, then drop it.
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++)
      send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Receiver: stall a random number of cycles per result, and once take a
  // long hold-off while the sender keeps pushing.
  initial begin
    int  stall;
    bit  taken;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = pick_gap(take_calm);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
    end
  end

  // Check every result at the falling edge before the edge that takes it.
  always @(negedge clk_i) begin
    fix_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.lat    = latitude_e5_o;
      got.lon    = longitude_e5_o;
      got.status = pcd_status_e'(status_o);
      got.last   = last_of_string_o;
      tracker.check_fix(got);
    end
  end

  // Hard stop if the run hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int n;
    int k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Point at the origin, then a lone latitude cut off by the end of string.
    push_value(32'd0);
    push_value(32'd0);
    push_value(32'hffff_ffff);
    send_line();
    // Too many continuation chunks, then a closing character that is dropped.
    push_run(CHAR_TOP, MAX_CHUNKS);
    line_q = {line_q, CHAR_OFFSET};
    send_line();
    // Bad character opens the string; the rest of it is dropped.
    line_q = {line_q, 8'd0};
    line_q = {line_q, 8'hff};
    send_line();
    // Bad characters on the last position: 8'hff, then just outside either end of the range.
    line_q = {line_q, 8'hff};
    send_line();
    line_q = {line_q, CHAR_OFFSET - 8'd1};
    send_line();
    line_q = {line_q, CHAR_TOP + 8'd1};
    send_line();
    // String ends in the middle of a value.
    line_q = {line_q, CHAR_OFFSET + 8'h20};
    send_line();
    // Longest legal value: the top payload bits overflow bit 31 and vanish.
    push_run(CHAR_TOP, MAX_CHUNKS - 1);
    line_q = {line_q, CHAR_OFFSET + 8'h1f};
    line_q = {line_q, CHAR_OFFSET};
    send_line();

    hold_request = 1'b1;

    // Random strings: mostly well-formed point lists, some damaged, some noise.
    while (sent_chars < N_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 5);
        repeat (n) begin
          push_value(pick_delta());
          push_value(pick_delta());
        end
        case ($urandom_range(0, 5))
          0: begin
            // Cut the string short.
            k = $urandom_range(1, line_q.size() - 1 > 0 ? line_q.size() - 1 : 1);
            while (line_q.size() > k) void'(line_q.pop_back());
          end
          1: line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
          2: begin
            // Splice in a run of continuation chunks longer than allowed.
            k = $urandom_range(0, line_q.size() - 1);
            repeat (MAX_CHUNKS + $urandom_range(0, 2))
              line_q.insert(k, 8'($urandom_range(32, 63)) + CHAR_OFFSET);
          end
          default: ;
        endcase
      end else begin
        repeat ($urandom_range(1, 10)) line_q = {line_q, 8'($urandom_range(0, 255))};
      end
      send_line();
    end
    in_valid_i <= 1'b0;

    // Drain: wait for all due results, then watch for strays.
    while (tracker.fixes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
